// File: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL files; included by grid_ray_dda_walk_core.
// Each macro expands to one labeled concurrent assertion with a reset guard.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion lbl failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion lbl failed");

`endif

// File: hw/rtl/gdda_pkg.sv
// Shared types and constants of the grid ray walker.
// No dependencies; used by every module of the block except gdda_ram.
`default_nettype none

package gdda_pkg;

	localparam int MAP_SIZE_DEF      = 64;
	localparam int SCREEN_HEIGHT_DEF = 1024;

	localparam int POS_W   = 16;
	localparam int FRAC_W  = 10;
	localparam int CELL_W  = 6;
	localparam int DELTA_W = 24;
	localparam int DIST_W  = 32;
	localparam int LINE_W  = 16;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_CAST  = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [CELL_W-1:0]  cell_col;
		logic [CELL_W-1:0]  cell_row;
		logic               cell_is_wall;
		logic [POS_W-1:0]   pos_x;
		logic [POS_W-1:0]   pos_y;
		logic               dir_x_negative;
		logic               dir_y_negative;
		logic [DELTA_W-1:0] delta_x;
		logic [DELTA_W-1:0] delta_y;
	} cmd_t;

	typedef struct packed {
		logic [LINE_W-1:0] line_height;
		logic              hit_side;
		logic [DIST_W-1:0] perp_distance;
		logic              escaped;
	} res_t;

	// Outcome of one DDA step, excluding the map coordinates.
	typedef struct packed {
		logic              side;
		logic              leave;
		logic [DIST_W-1:0] perp;
		logic [DIST_W-1:0] sx_nxt;
		logic [DIST_W-1:0] sy_nxt;
	} step_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/gdda_ram.sv
// Generic simple dual port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module gdda_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: hw/rtl/gdda_step.sv
// One DDA step: pick the nearer border, advance its side distance, move the cell.
// Depends on gdda_pkg.
`default_nettype none

module gdda_step #(
	parameter int MAP_SIZE = gdda_pkg::MAP_SIZE_DEF
) (
	input  wire logic [gdda_pkg::DIST_W-1:0]  sx,
	input  wire logic [gdda_pkg::DIST_W-1:0]  sy,
	input  wire logic [gdda_pkg::DELTA_W-1:0] dx,
	input  wire logic [gdda_pkg::DELTA_W-1:0] dy,
	input  wire logic                         neg_x,
	input  wire logic                         neg_y,
	input  wire logic [$clog2(MAP_SIZE)-1:0]  col,
	input  wire logic [$clog2(MAP_SIZE)-1:0]  row,
	output logic      [$clog2(MAP_SIZE)-1:0]  col_nxt,
	output logic      [$clog2(MAP_SIZE)-1:0]  row_nxt,
	output gdda_pkg::step_res_t               res
);
	import gdda_pkg::*;

	localparam int CW = $clog2(MAP_SIZE);
	localparam logic [CW-1:0] LAST = CW'(MAP_SIZE - 1);

	logic            take_x;
	logic [DIST_W:0] sum;
	logic [DIST_W-1:0] sat;

	assign take_x = sx < sy;
	assign sum    = take_x ? ({1'b0, sx} + (DIST_W + 1)'(dx))
	                       : ({1'b0, sy} + (DIST_W + 1)'(dy));
	assign sat    = sum[DIST_W] ? '1 : sum[DIST_W-1:0];

	always_comb begin
		res.side   = !take_x;
		res.perp   = take_x ? sx : sy;
		res.sx_nxt = take_x ? sat : sx;
		res.sy_nxt = take_x ? sy : sat;
		col_nxt    = col;
		row_nxt    = row;
		if (take_x) begin
			res.leave = neg_x ? (col == '0) : (col == LAST);
			col_nxt   = neg_x ? col - CW'(1) : col + CW'(1);
		end else begin
			res.leave = neg_y ? (row == '0) : (row == LAST);
			row_nxt   = neg_y ? row - CW'(1) : row + CW'(1);
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/gdda_div.sv
// Restoring serial divider: (SCREEN_HEIGHT << 16) / divisor, one bit a cycle.
// Quotient saturates at 16 bits. Depends on gdda_pkg.
`default_nettype none

module gdda_div #(
	parameter int SCREEN_HEIGHT = gdda_pkg::SCREEN_HEIGHT_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [gdda_pkg::DIST_W-1:0] divisor,
	output logic                             done,
	output logic      [gdda_pkg::LINE_W-1:0] quotient
);
	import gdda_pkg::*;

	localparam int DW  = $clog2(SCREEN_HEIGHT) + 17;
	localparam int CNW = $clog2(DW + 1);
	localparam logic [DW-1:0] DIVIDEND = DW'(SCREEN_HEIGHT) << 16;

	logic              busy_q;
	logic              done_q;
	logic [CNW-1:0]    cnt_q;
	logic [DW-1:0]     quo_q;
	logic [DIST_W-1:0] rem_q;
	logic [DIST_W-1:0] dvs_q;
	logic [DIST_W:0]   trial;
	logic              ge;
	logic [DIST_W:0]   diff;

	assign trial = {rem_q, quo_q[DW-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNW'(1);
				if (cnt_q == CNW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= DIVIDEND;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= ge ? diff[DIST_W-1:0] : trial[DIST_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = (|quo_q[DW-1:LINE_W]) ? '1 : quo_q[LINE_W-1:0];

endmodule

`default_nettype wire

// File: hw/rtl/grid_ray_dda_walk_core.sv
// Top level of the grid ray walker: sequencer, wall map, step unit, divider.
// Depends on gdda_pkg, gdda_ram, gdda_step, gdda_div and assert_macros.svh.
//
//  channel | dir | handshake           | payload
//  cmd     | in  | cmd_valid/cmd_stall | cmd (write cell or cast ray)
//  res     | out | res_valid/res_stall | res (one per cast)
//
// A write request is done when it is taken. A cast runs through the setup states
// SETX and SETY, then walks cell by cell (at most 2*MAP_SIZE+2 steps) with a map
// read per step, then runs the serial divider on a hit, and retires in FIN.
// After reset the map is cleared one cell a cycle, all MAP_SIZE*MAP_SIZE cells;
// cmd_stall stays high meanwhile. A stalled result waits in the output register
// while the next request is already taken.
`default_nettype none
`include "assert_macros.svh"

module grid_ray_dda_walk_core #(
	parameter int MAP_SIZE      = gdda_pkg::MAP_SIZE_DEF,
	parameter int SCREEN_HEIGHT = gdda_pkg::SCREEN_HEIGHT_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	output logic                cmd_stall,
	input  wire gdda_pkg::cmd_t cmd,
	output logic                res_valid,
	input  wire logic           res_stall,
	output gdda_pkg::res_t      res
);
	import gdda_pkg::*;

	localparam int CW    = $clog2(MAP_SIZE);
	localparam int DEPTH = MAP_SIZE * MAP_SIZE;
	localparam int MAW   = $clog2(DEPTH);
	localparam int LIMIT = 2 * MAP_SIZE + 2;
	localparam int SW    = $clog2(LIMIT + 1);
	localparam logic [8:0] MAP_W = 9'(MAP_SIZE);

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_SETX  = 7'b0000100,
		ST_SETY  = 7'b0001000,
		ST_WALK  = 7'b0010000,
		ST_DIV   = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [MAW-1:0]    clr_q;
	logic [SW-1:0]     steps_q;
	logic              chk_q;
	logic              res_valid_q;
	res_t              res_out_q;

	logic [FRAC_W-1:0]  frac_x_q, frac_y_q;
	logic               neg_x_q, neg_y_q;
	logic [DELTA_W-1:0] dx_q, dy_q;
	logic               start_ok_q;
	logic [CW-1:0]      col_q, row_q;
	logic [DIST_W-1:0]  sx_q, sy_q, perp_q;
	logic               side_q;
	res_t               res_q;

	logic               cmd_acc;
	logic               wr_ok;
	logic               ram_we;
	logic [MAW-1:0]     ram_waddr, ram_raddr;
	logic               ram_wdata, ram_rdata;
	logic [CW-1:0]      col_nxt, row_nxt;
	step_res_t          step;
	logic               hit_now;
	logic               lim;
	logic               div_start, div_done;
	logic [LINE_W-1:0]  div_quo;
	logic [FRAC_W:0]    part;
	logic [FRAC_W+DELTA_W:0] prod;
	logic [DIST_W-1:0]  border;
	logic               fin_go;

	function automatic logic [MAW-1:0] cell_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
		cell_addr = MAW'(r) * MAW'(MAP_SIZE) + MAW'(c);
	endfunction

	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign wr_ok     = ({3'b0, cmd.cell_col} < MAP_W) && ({3'b0, cmd.cell_row} < MAP_W);

	assign ram_we    = (state_q == ST_CLEAR) || (cmd_acc && cmd.kind == KIND_WRITE && wr_ok);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_q
	                 : cell_addr(CW'(cmd.cell_row), CW'(cmd.cell_col));
	assign ram_wdata = (state_q == ST_CLEAR) ? 1'b0 : cmd.cell_is_wall;
	assign ram_raddr = cell_addr(row_nxt, col_nxt);

	gdda_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	gdda_step #(
		.MAP_SIZE(MAP_SIZE)
	) u_step (
		.sx     (sx_q),
		.sy     (sy_q),
		.dx     (dx_q),
		.dy     (dy_q),
		.neg_x  (neg_x_q),
		.neg_y  (neg_y_q),
		.col    (col_q),
		.row    (row_q),
		.col_nxt(col_nxt),
		.row_nxt(row_nxt),
		.res    (step)
	);

	assign hit_now   = chk_q && ram_rdata;
	assign lim       = (steps_q == SW'(LIMIT));
	assign div_start = (state_q == ST_WALK) && hit_now;

	gdda_div #(
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor ((perp_q == '0) ? DIST_W'(1) : perp_q),
		.done    (div_done),
		.quotient(div_quo)
	);

	// First border distance; one multiplier serves both axes.
	always_comb begin
		if (state_q == ST_SETX) begin
			part = neg_x_q ? {1'b0, frac_x_q} : (FRAC_W + 1)'(1 << FRAC_W) - {1'b0, frac_x_q};
			prod = (FRAC_W + DELTA_W + 1)'(part) * (FRAC_W + DELTA_W + 1)'(dx_q);
		end else begin
			part = neg_y_q ? {1'b0, frac_y_q} : (FRAC_W + 1)'(1 << FRAC_W) - {1'b0, frac_y_q};
			prod = (FRAC_W + DELTA_W + 1)'(part) * (FRAC_W + DELTA_W + 1)'(dy_q);
		end
	end
	assign border = DIST_W'(prod[FRAC_W+DELTA_W:FRAC_W]);

	assign fin_go = (state_q == ST_FIN) && (!res_valid_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			steps_q     <= '0;
			chk_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + MAW'(1);
					if (clr_q == MAW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_acc && cmd.kind == KIND_CAST) begin
						state_q <= ST_SETX;
					end
				end
				ST_SETX: state_q <= ST_SETY;
				ST_SETY: begin
					steps_q <= '0;
					chk_q   <= 1'b0;
					state_q <= start_ok_q ? ST_WALK : ST_FIN;
				end
				ST_WALK: begin
					if (hit_now) begin
						state_q <= ST_DIV;
					end else if (lim || step.leave) begin
						state_q <= ST_FIN;
					end else begin
						steps_q <= steps_q + SW'(1);
						chk_q   <= 1'b1;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_acc && cmd.kind == KIND_CAST) begin
					frac_x_q   <= cmd.pos_x[FRAC_W-1:0];
					frac_y_q   <= cmd.pos_y[FRAC_W-1:0];
					col_q      <= CW'(cmd.pos_x[POS_W-1:FRAC_W]);
					row_q      <= CW'(cmd.pos_y[POS_W-1:FRAC_W]);
					start_ok_q <= ({3'b0, cmd.pos_x[POS_W-1:FRAC_W]} < MAP_W)
					           && ({3'b0, cmd.pos_y[POS_W-1:FRAC_W]} < MAP_W);
					neg_x_q    <= cmd.dir_x_negative;
					neg_y_q    <= cmd.dir_y_negative;
					dx_q       <= cmd.delta_x;
					dy_q       <= cmd.delta_y;
				end
			end
			ST_SETX: sx_q <= border;
			ST_SETY: begin
				sy_q                <= border;
				res_q.line_height   <= '0;
				res_q.hit_side      <= 1'b0;
				res_q.perp_distance <= '0;
				res_q.escaped       <= 1'b1;
			end
			ST_WALK: begin
				if (!hit_now && !lim && !step.leave) begin
					sx_q   <= step.sx_nxt;
					sy_q   <= step.sy_nxt;
					col_q  <= col_nxt;
					row_q  <= row_nxt;
					perp_q <= step.perp;
					side_q <= step.side;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					res_q.line_height   <= div_quo;
					res_q.hit_side      <= side_q;
					res_q.perp_distance <= perp_q;
					res_q.escaped       <= 1'b0;
				end
			end
			ST_FIN: begin
				if (fin_go) begin
					res_out_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_out_q;

	`ASSERT_IMP(a_div_in_div, clk, arst_n, div_done, state_q == ST_DIV)
	`ASSERT_IMP(a_step_limit, clk, arst_n, state_q == ST_WALK, steps_q <= SW'(LIMIT))
	`ASSERT_IMP(a_escape_zero, clk, arst_n, res_valid && res.escaped, res.line_height == '0 && res.perp_distance == '0 && !res.hit_side)
	`ASSERT_NXT(a_hit_to_div, clk, arst_n, state_q == ST_WALK && hit_now, state_q == ST_DIV)

endmodule

`default_nettype wire
